>>> rtl/palindromic_prime_test_core_defines.svh
// assertion macros for the rtl
`ifndef PALINDROMIC_PRIME_TEST_CORE_DEFINES_SVH
`define PALINDROMIC_PRIME_TEST_CORE_DEFINES_SVH

// same-cycle implication, inactive during reset
`define PPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive during reset
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ppt_pkg.sv
package ppt_pkg;

    // number base of the digit reversal
    localparam int unsigned DIGIT_BASE        = 10;
    // the one even prime
    localparam int unsigned SMALLEST_PRIME    = 2;
    // first odd trial divisor and the stride between divisors
    localparam int unsigned FIRST_ODD_DIVISOR = 3;
    localparam int unsigned DIV_STEP          = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAL_TEST,
        S_PAL_WAIT,
        S_PRIME_TEST,
        S_PRIME_LOOP,
        S_PRIME_WAIT,
        S_FINISH
    } ppt_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic digit_start;
        logic pal_step;
        logic pal_latch;
        logic prime_init;
        logic prime_step;
        logic prime_write;
        logic prime_val;
        logic out_load;
    } ppt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic digit_done;
        logic rest_zero;
        logic value_lt2;
        logic value_eq2;
        logic value_even;
        logic sq_gt;
        logic rem_zero;
    } ppt_status_t;

endpackage

>>> rtl/ppt_div.sv
module ppt_div #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int CW = $clog2(VALUE_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   trial;

    // restoring division, one quotient bit a cycle
    assign shifted = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], ~trial[VALUE_BITS]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/ppt_dp.sv
module ppt_dp #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppt_pkg::ppt_cmd_t     cmd,
    output ppt_pkg::ppt_status_t  status,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  is_prime,
    output logic                  is_palindrome,
    output logic                  is_palindromic_prime
);

    import ppt_pkg::*;

    // divisor, its square and the reversed number
    localparam int DW = (VALUE_BITS + 1) / 2 + 1;
    localparam int SW = VALUE_BITS + 2;
    localparam int RW = VALUE_BITS + 4;
    // one token bit per step of the divide-by-ten sequence
    localparam int DIG_STAGES = 6;

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] rest_reg;
    logic [RW-1:0]         rev_reg;
    logic [DW-1:0]         d_reg;
    logic [SW-1:0]         sq_reg;
    logic                  pal_reg;
    logic                  prime_reg;
    logic                  out_prime_reg;
    logic                  out_pal_reg;
    logic                  out_both_reg;
    logic [VALUE_BITS-1:0] dig_est_reg;
    logic [VALUE_BITS-1:0] dig_quo_reg;
    logic [VALUE_BITS-1:0] dig_rem_reg;
    logic [DIG_STAGES-1:0] dig_stage_reg;
    logic                  dig_done_reg;

    logic [VALUE_BITS-1:0] div_divisor;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_rem;
    logic [VALUE_BITS-1:0] dig_quo_est;
    logic [VALUE_BITS-1:0] dig_rem_est;
    logic                  dig_fix;
    logic [RW-1:0]         rev_times_ten;

    // trial divisor for the divider
    assign div_divisor = VALUE_BITS'(d_reg);

    ppt_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (value_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // divide by ten: estimate 0.8 of the number by shifts and adds, one add a cycle,
    // then divide by eight; the estimate is exact or one short, the remainder repairs it
    assign dig_quo_est = dig_est_reg >> 3;
    assign dig_rem_est = rest_reg - ((dig_quo_est << 3) + (dig_quo_est << 1));
    assign dig_fix     = (dig_rem_reg >= VALUE_BITS'(DIGIT_BASE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_stage_reg <= '0;
            dig_done_reg  <= 1'b0;
        end
        else
        begin
            dig_stage_reg <= cmd.digit_start ? DIG_STAGES'(1) : (dig_stage_reg << 1);
            dig_done_reg  <= dig_stage_reg[DIG_STAGES-1];
        end
    end

    // times ten as shift and add
    assign rev_times_ten = {rev_reg[RW-4:0], 3'b000} + {rev_reg[RW-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            rest_reg  <= value;
            rev_reg   <= '0;
        end
        if (cmd.digit_start)
            dig_est_reg <= (rest_reg >> 1) + (rest_reg >> 2);
        else if (dig_stage_reg[0])
            dig_est_reg <= dig_est_reg + (dig_est_reg >> 4);
        else if (dig_stage_reg[1])
            dig_est_reg <= dig_est_reg + (dig_est_reg >> 8);
        else if (dig_stage_reg[2])
            dig_est_reg <= dig_est_reg + (dig_est_reg >> 16);
        else if (dig_stage_reg[3])
            dig_est_reg <= dig_est_reg + (dig_est_reg >> 32);
        if (dig_stage_reg[4])
        begin
            dig_quo_reg <= dig_quo_est;
            dig_rem_reg <= dig_rem_est;
        end
        else if (dig_stage_reg[5] && dig_fix)
        begin
            dig_quo_reg <= dig_quo_reg + 1'b1;
            dig_rem_reg <= dig_rem_reg - VALUE_BITS'(DIGIT_BASE);
        end
        if (cmd.pal_step)
        begin
            rest_reg <= dig_quo_reg;
            rev_reg  <= rev_times_ten + RW'(dig_rem_reg);
        end
        if (cmd.pal_latch)
            pal_reg <= (rev_reg == RW'(value_reg));
        if (cmd.prime_init)
        begin
            d_reg  <= DW'(FIRST_ODD_DIVISOR);
            sq_reg <= SW'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
        end
        if (cmd.prime_step)
        begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_reg  <= d_reg + DW'(DIV_STEP);
            sq_reg <= sq_reg + (SW'(d_reg) << 2) + SW'(DIV_STEP * DIV_STEP);
        end
        if (cmd.prime_write)
            prime_reg <= cmd.prime_val;
        if (cmd.out_load)
        begin
            out_prime_reg <= prime_reg;
            out_pal_reg   <= pal_reg;
            out_both_reg  <= prime_reg & pal_reg;
        end
    end

    always_comb
    begin
        status.div_done   = div_done;
        status.digit_done = dig_done_reg;
        status.rest_zero  = (rest_reg == '0);
        status.value_lt2  = (value_reg < VALUE_BITS'(SMALLEST_PRIME));
        status.value_eq2  = (value_reg == VALUE_BITS'(SMALLEST_PRIME));
        status.value_even = ~value_reg[0];
        status.sq_gt      = (sq_reg > SW'(value_reg));
        status.rem_zero   = (div_rem == '0);
    end

    assign is_prime             = out_prime_reg;
    assign is_palindrome        = out_pal_reg;
    assign is_palindromic_prime = out_both_reg;

endmodule

>>> rtl/ppt_ctrl.sv
`include "palindromic_prime_test_core_defines.svh"

module ppt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  ppt_pkg::ppt_status_t status,
    output ppt_pkg::ppt_cmd_t    cmd
);

    import ppt_pkg::*;

    ppt_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = ~out_valid_reg | ~out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_PAL_TEST;
            S_PAL_TEST:
                state_next = status.rest_zero ? S_PRIME_TEST : S_PAL_WAIT;
            S_PAL_WAIT:
                if (status.digit_done)
                    state_next = S_PAL_TEST;
            S_PRIME_TEST:
                if (status.value_lt2 || status.value_eq2 || status.value_even)
                    state_next = S_FINISH;
                else
                    state_next = S_PRIME_LOOP;
            S_PRIME_LOOP:
                state_next = status.sq_gt ? S_FINISH : S_PRIME_WAIT;
            S_PRIME_WAIT:
                if (status.div_done)
                    state_next = status.rem_zero ? S_FINISH : S_PRIME_LOOP;
            S_FINISH:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
                cmd.load = in_valid;
            S_PAL_TEST:
            begin
                cmd.pal_latch   = status.rest_zero;
                cmd.digit_start = ~status.rest_zero;
            end
            S_PAL_WAIT:
                cmd.pal_step = status.digit_done;
            S_PRIME_TEST:
            begin
                cmd.prime_write = status.value_lt2 | status.value_eq2 | status.value_even;
                cmd.prime_val   = status.value_eq2;
                cmd.prime_init  = ~cmd.prime_write;
            end
            S_PRIME_LOOP:
            begin
                cmd.prime_write = status.sq_gt;
                cmd.prime_val   = 1'b1;
                cmd.div_start   = ~status.sq_gt;
            end
            S_PRIME_WAIT:
            begin
                cmd.prime_write = status.div_done & status.rem_zero;
                cmd.prime_val   = 1'b0;
                cmd.prime_step  = status.div_done & ~status.rem_zero;
            end
            S_FINISH:
                cmd.out_load = out_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `PPT_ASSERT_NOW(a_load_only_when_free, clk, rst_n, cmd.out_load,
        !out_valid_reg || !out_stall, "result loaded over an untaken result")
    `PPT_ASSERT_NOW(a_div_done_expected, clk, rst_n, status.div_done,
        state_reg == S_PRIME_WAIT, "divider finished unexpectedly")
    `PPT_ASSERT_NOW(a_digit_done_expected, clk, rst_n, status.digit_done,
        state_reg == S_PAL_WAIT, "digit step finished unexpectedly")
    `PPT_ASSERT_NOW(a_single_update, clk, rst_n, 1'b1,
        $onehot0({cmd.pal_step, cmd.prime_write, cmd.prime_step, cmd.out_load}),
        "conflicting datapath updates")
    `PPT_ASSERT_NEXT(a_request_starts_walk, clk, rst_n, in_valid && !in_stall,
        state_reg == S_PAL_TEST, "accepted request did not start digit walk")

endmodule

>>> rtl/palindromic_prime_test_core.sv
// run time from request to result grows with the number D of decimal digits of the value, plus
//   one trial division per odd divisor tried and a final check when the divisor square passes the value
// one request at a time: a new request is taken only in idle, once the last result is loaded;
//   the worst case is set by the one-bit-per-cycle trial divider
// a finished result may wait on the output while the next request is taken in
// reset: asynchronous, active low; returns to idle with no result pending
module palindromic_prime_test_core #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  is_prime,
    output logic                  is_palindrome,
    output logic                  is_palindromic_prime
);

    import ppt_pkg::*;

    // command and status between sequencer and datapath
    ppt_cmd_t    cmd;
    ppt_status_t status;

    // sequencer: digit walk first, then the trivial prime cases,
    // then odd divisors from three while the divisor square stays within the value
    ppt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: value, digit remainder, reversed number, divisor and its square,
    // the divide-by-ten unit, the trial divider and the registered result flags
    ppt_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .value                (value),
        .is_prime             (is_prime),
        .is_palindrome        (is_palindrome),
        .is_palindromic_prime (is_palindromic_prime)
    );

endmodule

>>> tb/sv/tb_palindromic_prime_test_core.sv
module tb_palindromic_prime_test_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;

    localparam int VALUE_BITS = 31;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;

    // random requests per idling phase, four phases in all
    localparam int RANDOM_PER_PHASE = 19;
    // cap on odd divisors tried for a random request, bounds its trial division time
    localparam int unsigned MAX_TRIES = 150;
    // settling time after the last result, in clock cycles
    localparam int DRAIN_CYCLES = 2000;

    // how each side idles while a request is being worked on
    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    // chance in a hundred, indexed by phase
    localparam int unsigned SENDER_IDLE_PCT [4]    = '{0, 67, 0, 25};
    localparam int unsigned RECEIVER_STALL_PCT [4] = '{0, 0, 67, 25};

    // corner values: boundaries of the prime test, palindromes, bit patterns, the extremes
    localparam bit [VALUE_BITS-1:0] CORNER_VALUES [25] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7, 31'd9, 31'd10, 31'd11,
        31'd25, 31'd49, 31'd101, 31'd121, 31'd131, 31'd919,
        31'd1000000001, 31'd1234554321, 31'd2147447412,
        31'd1073741823, 31'd1073741824, 31'd1431655765, 31'd715827882,
        31'd2147483646, 31'd2147483647
    };

    typedef struct {
        bit [VALUE_BITS-1:0] number;
        idle_phase_t         phase;
    } request_t;

    typedef struct {
        bit [VALUE_BITS-1:0] number;
        bit                  prime;
        bit                  palindrome;
        bit                  palindromic_prime;
        idle_phase_t         phase;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] value     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_prime;
    logic                  is_palindrome;
    logic                  is_palindromic_prime;

    // requests still to be driven, and the verdicts owed for accepted ones
    request_t    request_q [$];
    verdict_t    verdict_q [$];
    idle_phase_t driven_phase = PH_STEADY;
    int          mismatch_count = 0;

    palindromic_prime_test_core #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .value               (value),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .is_prime            (is_prime),
        .is_palindrome       (is_palindrome),
        .is_palindromic_prime(is_palindromic_prime)
    );

    // trial division by odd divisors while the divisor squared stays within n
    // tries counts the divisors looked at, which sets the block's run time
    function automatic bit prime_by_division(input longint unsigned n,
                                             output int unsigned tries);
        longint unsigned d;
        tries = 0;
        if (n < SMALLEST_PRIME)
            return 1'b0;
        if (n == SMALLEST_PRIME)
            return 1'b1;
        if (n % 2 == 0)
            return 1'b0;
        for (d = FIRST_ODD_DIVISOR; d <= n / d; d += DIV_STEP)
        begin
            tries++;
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // rebuild the number from its decimal digits in reverse order
    function automatic bit reads_same_reversed(input longint unsigned n);
        longint unsigned rev;
        longint unsigned rest;
        rev  = 0;
        rest = n;
        while (rest > 0)
        begin
            rev  = rev * DIGIT_BASE + rest % DIGIT_BASE;
            rest = rest / DIGIT_BASE;
        end
        return rev == n;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // request driver: valid and payload held until the block takes them
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        verdict_t    owed;
        int unsigned tries;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            // a request taken at this edge: work out what it must produce
            if (in_valid)
            begin
                owed.number            = value;
                owed.prime             = prime_by_division(value, tries);
                owed.palindrome        = reads_same_reversed(value);
                owed.palindromic_prime = owed.prime & owed.palindrome;
                owed.phase             = driven_phase;
                verdict_q.push_back(owed);
            end
            // next request, or a gap as the phase of that request asks
            if (request_q.size() != 0 &&
                $urandom_range(99) >= SENDER_IDLE_PCT[request_q[0].phase])
            begin
                in_valid     <= 1'b1;
                value        <= request_q[0].number;
                driven_phase <= request_q[0].phase;
                void'(request_q.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor: checks every accepted result against the oldest verdict owed
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        verdict_t owed;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    owed = verdict_q.pop_front();
                    if (is_prime !== owed.prime)
                        report_mismatch($sformatf("value %0d is_prime got %b want %b",
                                                  owed.number, is_prime, owed.prime));
                    if (is_palindrome !== owed.palindrome)
                        report_mismatch($sformatf("value %0d is_palindrome got %b want %b",
                                                  owed.number, is_palindrome,
                                                  owed.palindrome));
                    if (is_palindromic_prime !== owed.palindromic_prime)
                        report_mismatch($sformatf("value %0d is_palindromic_prime got %b want %b",
                                                  owed.number, is_palindromic_prime,
                                                  owed.palindromic_prime));
                end
            end
            // stall at the rate of the phase of the request being worked on
            if (verdict_q.size() != 0 &&
                $urandom_range(99) < RECEIVER_STALL_PCT[verdict_q[0].phase])
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    // stimulus: corner values first, then random requests phase by phase
    initial
    begin : stimulus
        longint unsigned candidate;
        int unsigned     tries;
        int unsigned     pick;
        int unsigned     digits;
        int unsigned     half_digits [10];
        rst_n = 1'b0;

        foreach (CORNER_VALUES[i])
            request_q.push_back('{CORNER_VALUES[i], PH_STEADY});

        for (int p = PH_STEADY; p <= PH_BOTH_IDLE; p++)
        begin
            repeat (RANDOM_PER_PHASE)
            begin
                // draw until the trial division stays short, so large primes are skipped
                do
                begin
                    pick = $urandom_range(3);
                    case (pick)
                        0: candidate = $urandom_range(999);
                        1: candidate = $urandom_range(65535, 1000);
                        2: candidate = longint'($urandom()) & VALUE_MAX;
                        default:
                        begin
                            // mirrored digit string, leading zeros allowed
                            digits    = $urandom_range(10, 1);
                            candidate = 0;
                            for (int k = 0; k < 10; k++)
                                half_digits[k] = $urandom_range(9);
                            for (int k = 0; k < digits; k++)
                                candidate = candidate * DIGIT_BASE +
                                            half_digits[(k < digits - 1 - k) ?
                                                        k : digits - 1 - k];
                        end
                    endcase
                    if (candidate > VALUE_MAX)
                        tries = MAX_TRIES + 1;
                    else
                        void'(prime_by_division(candidate, tries));
                end
                while (tries > MAX_TRIES);
                request_q.push_back('{candidate[VALUE_BITS-1:0], idle_phase_t'(p)});
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // run until every request is in and every verdict settled
        while (request_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog: a time limit several times the slowest correct run,
    // which is dominated by the largest 31-bit prime
    initial
    begin : watchdog
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> palindromic_prime_test_core.f
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_div.sv
rtl/ppt_dp.sv
rtl/ppt_ctrl.sv
rtl/palindromic_prime_test_core.sv
tb/sv/tb_palindromic_prime_test_core.sv
